// ===== src/source_comment_blanker_unit_defines.svh =====
// assertion helpers for the comment blanker
`ifndef SOURCE_COMMENT_BLANKER_UNIT_DEFINES_SVH
`define SOURCE_COMMENT_BLANKER_UNIT_DEFINES_SVH

// same-cycle implication, disabled while reset is high
`define SCB_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled while reset is high
`define SCB_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== src/scb_pkg.sv =====
package scb_pkg;

   localparam logic [7:0] CH_NL    = 8'h0A;
   localparam logic [7:0] CH_SP    = 8'h20;
   localparam logic [7:0] CH_SLASH = 8'h2F;
   localparam logic [7:0] CH_STAR  = 8'h2A;
   localparam logic [7:0] CH_HASH  = 8'h23;
   localparam logic [7:0] CH_BANG  = 8'h21;

   // output queue geometry
   localparam int QUEUE_DEPTH = 3;
   localparam int OCC_WIDTH   = 2;

   typedef enum logic [1:0] {
      LANG_C       = 2'd0,
      LANG_PYTHON  = 2'd1,
      LANG_FORTRAN = 2'd2,
      LANG_NONE    = 2'd3
   } lang_type;

   typedef struct packed {
      logic [7:0] ch;
      logic       last;
   } entry_type;

   // up to two result bytes produced by one accepted input byte
   typedef struct packed {
      logic [1:0] cnt;
      entry_type  e0;
      entry_type  e1;
   } push_type;

   typedef struct packed {
      logic held;
      logic line;
      logic block;
   } status_type;

endpackage

// ===== src/scb_core.sv =====
module scb_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_wr_en,
   input  logic [1:0]         csr_wr_data,
   input  logic               in_fire,
   input  logic [7:0]         in_char,
   input  logic               in_eof,
   output scb_pkg::push_type   push,
   output scb_pkg::status_type status
);
   import scb_pkg::*;

   typedef struct packed {
      logic       emit;
      logic [7:0] ch;
      logic       hold;
      logic       line;
      logic       block;
      logic       star;
   } proc_type;

   lang_type lang_ff;
   logic     held_ff, held_in;
   logic     line_ff, line_in;
   logic     block_ff, block_in;
   logic     star_ff, star_in;

   proc_type   p;
   logic [1:0] cnt;
   logic [7:0] c0, c1;

   // one byte outside any lookahead
   function automatic proc_type process_byte(lang_type lang, logic [7:0] ch,
                                             logic line, logic block, logic star);
      proc_type r;
      r.emit  = 1'b1;
      r.ch    = ch;
      r.hold  = 1'b0;
      r.line  = line;
      r.block = block;
      r.star  = star;
      if (block) begin
         if (star && ch == CH_SLASH) begin
            r.block = 1'b0;
            r.star  = 1'b0;
            r.ch    = CH_SP;
         end else begin
            r.star = (ch == CH_STAR);
            r.ch   = (ch == CH_NL) ? CH_NL : CH_SP;
         end
      end else if (line) begin
         if (ch == CH_NL) begin
            r.line = 1'b0;
         end else begin
            r.ch = CH_SP;
         end
      end else if (lang == LANG_C && ch == CH_SLASH) begin
         r.emit = 1'b0;
         r.hold = 1'b1;
      end else if ((lang == LANG_PYTHON && ch == CH_HASH) ||
                   (lang == LANG_FORTRAN && ch == CH_BANG)) begin
         r.line = 1'b1;
         r.ch   = CH_SP;
      end
      return r;
   endfunction

   always_comb begin
      p        = process_byte(lang_ff, in_char, line_ff, block_ff, star_ff);
      held_in  = p.hold;
      line_in  = p.line;
      block_in = p.block;
      star_in  = p.star;
      cnt      = {1'b0, p.emit};
      c0       = p.ch;
      c1       = p.ch;
      if (held_ff && lang_ff == LANG_C && in_char == CH_SLASH) begin
         held_in  = 1'b0;
         line_in  = 1'b1;
         block_in = 1'b0;
         star_in  = 1'b0;
         cnt      = 2'd2;
         c0       = CH_SP;
         c1       = CH_SP;
      end else if (held_ff && lang_ff == LANG_C && in_char == CH_STAR) begin
         held_in  = 1'b0;
         line_in  = 1'b0;
         block_in = 1'b1;
         star_in  = 1'b0;
         cnt      = 2'd2;
         c0       = CH_SP;
         c1       = CH_SP;
      end else if (held_ff) begin
         // released slash goes first, then the new byte
         cnt = p.emit ? 2'd2 : 2'd1;
         c0  = CH_SLASH;
      end
      if (in_eof) begin
         // flush a slash that is still held
         if (held_in && cnt == 2'd0) begin
            cnt = 2'd1;
            c0  = CH_SLASH;
         end else if (held_in && cnt == 2'd1) begin
            cnt = 2'd2;
            c1  = CH_SLASH;
         end
         held_in  = 1'b0;
         line_in  = 1'b0;
         block_in = 1'b0;
         star_in  = 1'b0;
      end
   end

   always_comb begin
      push.cnt     = in_fire ? cnt : 2'd0;
      push.e0.ch   = c0;
      push.e0.last = in_eof && cnt == 2'd1;
      push.e1.ch   = c1;
      push.e1.last = in_eof && cnt == 2'd2;
      status.held  = held_ff;
      status.line  = line_ff;
      status.block = block_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lang_ff  <= LANG_C;
         held_ff  <= 1'b0;
         line_ff  <= 1'b0;
         block_ff <= 1'b0;
         star_ff  <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            lang_ff <= lang_type'(csr_wr_data);
         end
         if (in_fire) begin
            held_ff  <= held_in;
            line_ff  <= line_in;
            block_ff <= block_in;
            star_ff  <= star_in;
         end
      end
   end

endmodule

// ===== src/scb_out_queue.sv =====
module scb_out_queue (
   input  logic                           clock,
   input  logic                           reset,
   input  scb_pkg::push_type              push,
   input  logic                           pop_ready,
   output logic                           head_valid,
   output scb_pkg::entry_type             head,
   output logic [scb_pkg::OCC_WIDTH-1:0]  occ
);
   import scb_pkg::*;

   entry_type             q_ff [QUEUE_DEPTH];
   entry_type             q_in [QUEUE_DEPTH];
   entry_type             sh   [QUEUE_DEPTH];
   logic [OCC_WIDTH-1:0]  occ_ff, occ_in, occ_pop;
   logic                  pop;

   assign head_valid = (occ_ff != '0);
   assign head       = q_ff[0];
   assign occ        = occ_ff;
   assign pop        = head_valid && pop_ready;
   assign occ_pop    = occ_ff - OCC_WIDTH'(pop);
   assign occ_in     = occ_pop + push.cnt;

   // queue contents after the head leaves
   always_comb begin
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         sh[i] = (i < QUEUE_DEPTH - 1) ? q_ff[(i + 1) % QUEUE_DEPTH] : q_ff[i];
      end
   end

   always_comb begin
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         if (OCC_WIDTH'(i) < occ_pop) begin
            q_in[i] = pop ? sh[i] : q_ff[i];
         end else if (OCC_WIDTH'(i) == occ_pop) begin
            q_in[i] = push.e0;
         end else begin
            q_in[i] = push.e1;
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         q_ff[i] <= q_in[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff <= '0;
      end else begin
         occ_ff <= occ_in;
      end
   end

endmodule

// ===== src/source_comment_blanker_unit.sv =====
// comment blanker: one source byte in per cycle while req_tready is high, comment bytes out as spaces
// a byte is registered in the output queue before it shows on rsp; a slash waits for the next byte
// throughput: one byte per cycle while req_tready is high; a byte that yields two results queues both
// req_tready is high while the three-entry output queue holds at most one byte
// reset (synchronous, active high) clears the language to C, the scanner state and the queue
`include "source_comment_blanker_unit_defines.svh"

module source_comment_blanker_unit (
   input  logic       clock,
   input  logic       reset,
   // configuration: comment language
   input  logic       csr_wr_en,
   input  logic [1:0] csr_wr_data,
   // source bytes
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] in_char
   input  logic       req_tlast,   // end_of_file
   // blanked bytes
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] out_char
   output logic       rsp_tlast    // last
);
   import scb_pkg::*;

   push_type             push;
   status_type           status;
   entry_type            head;
   logic [OCC_WIDTH-1:0] occ;
   logic                 req_fire;

   // a transfer may add two bytes, so keep two entries free
   assign req_tready = (occ <= OCC_WIDTH'(1));
   assign req_fire   = req_tvalid && req_tready;

   // scanner state and per-byte decision
   scb_core u_core (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .in_fire     (req_fire),
      .in_char     (req_tdata),
      .in_eof      (req_tlast),
      .push        (push),
      .status      (status)
   );

   // output queue decouples rsp stalls from incoming bytes
   scb_out_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .pop_ready  (rsp_tready),
      .head_valid (rsp_tvalid),
      .head       (head),
      .occ        (occ)
   );

   assign rsp_tdata = head.ch;
   assign rsp_tlast = head.last;

   // the end of a text always leaves at least one byte behind it
   `SCB_ASSERT_NOW(a_eof_emits, req_fire && req_tlast, push.cnt != 2'd0, "eof transfer without result")
   // scanner state is clean after the end of a text
   `SCB_ASSERT_NEXT(a_eof_clears, req_fire && req_tlast, !status.held && !status.line && !status.block, "state not cleared after eof")
   // a held slash only exists outside comments
   `SCB_ASSERT_NOW(a_held_outside, status.held, !status.line && !status.block, "slash held inside a comment")
   // a two-byte push never lands on a full queue
   `SCB_ASSERT_NOW(a_queue_room, push.cnt != 2'd0, occ <= OCC_WIDTH'(1), "output queue overflow")

endmodule
